/* hw/rtl/chip8_timer_tone_unit_top_macros.svh */
// ----------------------------------------------------------------------------
// Timer tone unit assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CHIP8_TIMER_TONE_UNIT_TOP_MACROS_SVH
`define CHIP8_TIMER_TONE_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TTU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ttu_pkg.sv */
// ----------------------------------------------------------------------------
// Timer tone unit package
// Codes, reset values, microprogram and sine table builder.
// ----------------------------------------------------------------------------
package ttu_pkg;

	localparam int SINE_INDEX_BITS_DEF = 8;
	localparam int SAMPLE_BITS_DEF     = 16;

	// request function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_SAMP  = 2'd1;
	localparam logic [1:0] FUNC_LDD   = 2'd2;
	localparam logic [1:0] FUNC_LDS   = 2'd3;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP  = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_GAIN   = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_VOLUME = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SNAP_LEVEL  = 4'd3;

	localparam logic [31:0] PHASE_STEP_RST  = 32'd42852281;
	localparam logic [15:0] RAMP_GAIN_RST   = 16'd655;
	localparam logic [14:0] PEAK_VOLUME_RST = 15'd16384;
	localparam logic [14:0] SNAP_LEVEL_RST  = 15'd3;

	localparam logic [14:0] LEVEL_MAX = 15'h7fff;

	// microprogram addresses
	localparam int UPC_BITS = 3;
	localparam logic [UPC_BITS-1:0] UPC_IDLE = 3'd0;
	localparam logic [UPC_BITS-1:0] UPC_TICK = 3'd1;
	localparam logic [UPC_BITS-1:0] UPC_LDD  = 3'd2;
	localparam logic [UPC_BITS-1:0] UPC_LDS  = 3'd3;
	localparam logic [UPC_BITS-1:0] UPC_S0   = 3'd4;
	localparam logic [UPC_BITS-1:0] UPC_S1   = 3'd5;
	localparam logic [UPC_BITS-1:0] UPC_S2   = 3'd6;
	localparam logic [UPC_BITS-1:0] UPC_S3   = 3'd7;

	typedef enum logic [1:0] {
		J_NEXT     = 2'd0,
		J_RET      = 2'd1,
		J_DISPATCH = 2'd2
	} jump_t;

	typedef enum logic [1:0] {
		T_NONE = 2'd0,
		T_TICK = 2'd1,
		T_LDD  = 2'd2,
		T_LDS  = 2'd3
	} timer_op_t;

	typedef enum logic [1:0] {
		M_NONE = 2'd0,
		M_RAMP = 2'd1,
		M_TONE = 2'd2
	} mul_sel_t;

	typedef struct packed {
		jump_t     jump;
		timer_op_t timer_op;
		mul_sel_t  mul_sel;
		logic      rom_rd;
		logic      lvl_we;
		logic      phase_we;
		logic      out_we;
		logic      samp_out;
	} ucode_t;

	function automatic ucode_t ucode(logic [UPC_BITS-1:0] addr);
		ucode_t w;
		w = '{jump: J_RET, timer_op: T_NONE, mul_sel: M_NONE, default: 1'b0};
		unique case (addr)
			UPC_IDLE: w.jump = J_DISPATCH;
			UPC_TICK: begin
				w.timer_op = T_TICK;
				w.out_we   = 1'b1;
			end
			UPC_LDD: begin
				w.timer_op = T_LDD;
				w.out_we   = 1'b1;
			end
			UPC_LDS: begin
				w.timer_op = T_LDS;
				w.out_we   = 1'b1;
			end
			UPC_S0: begin
				w.jump    = J_NEXT;
				w.mul_sel = M_RAMP;
				w.rom_rd  = 1'b1;
			end
			UPC_S1: begin
				w.jump   = J_NEXT;
				w.lvl_we = 1'b1;
			end
			UPC_S2: begin
				w.jump    = J_NEXT;
				w.mul_sel = M_TONE;
			end
			UPC_S3: begin
				w.phase_we = 1'b1;
				w.out_we   = 1'b1;
				w.samp_out = 1'b1;
			end
			default: w.jump = J_RET;
		endcase
		return w;
	endfunction

	// quarter-wave polynomial constants, fixed point with 28 fraction bits
	localparam logic [63:0] FX_ONE     = 64'd1 << 28;
	localparam logic [63:0] HALF_PI_FX = 64'd421657428;
	localparam logic [63:0] TERM_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	// Entry k of a 2**bits entry sine table, amplitude 32767; evaluated at elaboration.
	function automatic logic signed [15:0] sine_entry(int k, int bits);
		int          qb;
		int          quad;
		logic [63:0] mm;
		logic [63:0] m;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic [15:0] mag;
		qb   = bits - 2;
		quad = k >> qb;
		mm   = 64'(k) & ((64'd1 << qb) - 64'd1);
		m    = quad[0] ? ((64'd1 << qb) - mm) : mm;
		x    = (HALF_PI_FX * m) >> qb;
		x2   = (x * x) >> 28;
		acc  = FX_ONE;
		for (int i = 0; i < 6; i++) begin
			t   = ((x2 * acc) >> 28) / TERM_DIV[i];
			acc = (t >= FX_ONE) ? 64'd0 : FX_ONE - t;
		end
		s = (x * acc) >> 28;
		v = (s * 64'd32767 + (FX_ONE >> 1)) >> 28;
		if (v > 64'd32767)
			v = 64'd32767;
		mag = v[15:0];
		return quad[1] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

/* hw/rtl/chip8_timer_tone_unit_top.sv */
// ----------------------------------------------------------------------------
// Timer tone unit
// Delay and sound down-counters with an enveloped sine beeper.
// ----------------------------------------------------------------------------
// Each request (func in s_tuser) yields one result on m_tdata. A tick or a
// timer load runs its TICK, LDD or LDS step; a sample request runs a four-step
// microprogram that takes the envelope update and the tone product through one
// shared 17x17 multiplier and a registered sine ROM read. Requests are taken only
// in idle. The result sits in an output register, so a new request is taken
// while it waits; a held result stalls only the final step of the next request.
// Config writes are taken every cycle and are meant for idle periods.
`include "chip8_timer_tone_unit_top_macros.svh"

module chip8_timer_tone_unit_top
	import ttu_pkg::*;
#(
	parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	localparam int OUT_W   = SAMPLE_BITS + 17,
	localparam int TDATA_W = ((OUT_W + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // load_value
	input  logic [1:0]                s_tuser,   // func
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// sample, delay_value, sound_value, tone_on, zero pad
	output logic [TDATA_W-1:0]        m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [31:0]               cfg_data
);

	localparam int SINE_SIZE = 1 << SINE_INDEX_BITS;
	localparam int SHIFT     = 31 - SAMPLE_BITS;

	logic [31:0]               phase_step_q;
	logic [15:0]               ramp_gain_q;
	logic [14:0]               peak_volume_q;
	logic [14:0]               snap_level_q;
	logic [UPC_BITS-1:0]       upc_q;
	logic [1:0]                func_q;
	logic [7:0]                load_q;
	logic [7:0]                delay_q;
	logic [7:0]                sound_q;
	logic [31:0]               phase_q;
	logic [14:0]               level_q;
	logic signed [15:0]        sine_q;
	logic signed [33:0]        prod_q;
	logic                      out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic [7:0]                out_delay_q;
	logic [7:0]                out_sound_q;

	ucode_t                    uc;
	logic                      adv;
	logic                      out_load;
	logic [UPC_BITS-1:0]       entry;
	logic [7:0]                delay_nxt;
	logic [7:0]                sound_nxt;
	logic [14:0]               target;
	logic signed [16:0]        mul_a;
	logic signed [16:0]        mul_b;
	logic signed [17:0]        ramp_step;
	logic signed [18:0]        lvl_raw;
	logic [14:0]               lvl_nxt;
	logic signed [15:0]        sine_rom [SINE_SIZE];

	for (genvar k = 0; k < SINE_SIZE; k++) begin : g_rom
		localparam logic signed [15:0] SINE_VAL = sine_entry(k, SINE_INDEX_BITS);
		assign sine_rom[k] = SINE_VAL;
	end

	assign uc        = ucode(upc_q);
	assign s_tready  = (upc_q == UPC_IDLE);
	assign cfg_ready = 1'b1;
	// hold the closing step while the previous result is still unread
	assign adv       = !(uc.out_we && out_valid_q && !m_tready);
	assign out_load  = uc.out_we && adv;

	always_comb begin
		unique case (s_tuser)
			FUNC_TICK: entry = UPC_TICK;
			FUNC_SAMP: entry = UPC_S0;
			FUNC_LDD:  entry = UPC_LDD;
			FUNC_LDS:  entry = UPC_LDS;
			default:   entry = UPC_IDLE;
		endcase
	end

	always_comb begin
		delay_nxt = delay_q;
		sound_nxt = sound_q;
		unique case (uc.timer_op)
			T_TICK: begin
				if (delay_q != 8'd0)
					delay_nxt = delay_q - 8'd1;
				if (sound_q != 8'd0)
					sound_nxt = sound_q - 8'd1;
			end
			T_LDD:   delay_nxt = load_q;
			T_LDS:   sound_nxt = load_q;
			default: ;
		endcase
	end

	// shared multiplier operands: envelope error by gain, or level by sine
	always_comb begin
		target = (sound_q != 8'd0) ? peak_volume_q : 15'd0;
		unique case (uc.mul_sel)
			M_RAMP: begin
				mul_a = $signed({2'b00, target}) - $signed({2'b00, level_q});
				mul_b = $signed({1'b0, ramp_gain_q});
			end
			M_TONE: begin
				mul_a = $signed({2'b00, level_q});
				mul_b = $signed({sine_q[15], sine_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// floor shift of the ramp product, then snap and clamp
	always_comb begin
		ramp_step = prod_q[33:16];
		lvl_raw   = $signed({4'b0000, level_q}) + $signed({ramp_step[17], ramp_step});
		if (sound_q == 8'd0 && lvl_raw < $signed({4'b0000, snap_level_q}))
			lvl_nxt = 15'd0;
		else if (lvl_raw < 0)
			lvl_nxt = 15'd0;
		else if (lvl_raw > $signed({4'b0000, LEVEL_MAX}))
			lvl_nxt = LEVEL_MAX;
		else
			lvl_nxt = lvl_raw[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= PHASE_STEP_RST;
			ramp_gain_q   <= RAMP_GAIN_RST;
			peak_volume_q <= PEAK_VOLUME_RST;
			snap_level_q  <= SNAP_LEVEL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PHASE_STEP:  phase_step_q  <= cfg_data;
				REG_RAMP_GAIN:   ramp_gain_q   <= cfg_data[15:0];
				REG_PEAK_VOLUME: peak_volume_q <= cfg_data[14:0];
				REG_SNAP_LEVEL:  snap_level_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= UPC_IDLE;
			delay_q     <= 8'd0;
			sound_q     <= 8'd0;
			phase_q     <= 32'd0;
			level_q     <= 15'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				unique case (uc.jump)
					J_NEXT:     upc_q <= upc_q + UPC_BITS'(1);
					J_DISPATCH: upc_q <= s_tvalid ? entry : UPC_IDLE;
					default:    upc_q <= UPC_IDLE;
				endcase
			end
			if (out_load) begin
				delay_q <= delay_nxt;
				sound_q <= sound_nxt;
			end
			if (uc.phase_we && adv)
				phase_q <= phase_q + phase_step_q;
			if (uc.lvl_we)
				level_q <= lvl_nxt;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser;
			load_q <= s_tdata;
		end
		if (uc.rom_rd)
			sine_q <= sine_rom[phase_q[31 -: SINE_INDEX_BITS]];
		if (uc.mul_sel != M_NONE)
			prod_q <= mul_a * mul_b;
		if (out_load) begin
			out_sample_q <= uc.samp_out ? prod_q[SHIFT +: SAMPLE_BITS] : '0;
			out_delay_q  <= delay_nxt;
			out_sound_q  <= sound_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'({(out_sound_q != 8'd0), out_sound_q, out_delay_q, out_sample_q});

	`TTU_ASSERT_IMPL(a_level_range, 1'b1, level_q <= LEVEL_MAX, "envelope level out of range")
	`TTU_ASSERT_IMPL(a_no_overwrite, out_load, !(out_valid_q && !m_tready),
		"result register overwritten before it was taken")
	`TTU_ASSERT_NEXT(a_phase_hold, !(uc.phase_we && adv), $stable(phase_q),
		"phase moved outside a sample request")
	`TTU_ASSERT_NEXT(a_func_match, s_tvalid && s_tready && s_tuser == FUNC_SAMP,
		upc_q == UPC_S0 && func_q == FUNC_SAMP, "sample request not dispatched")

endmodule

/* tb/sv/chip8_timer_tone_unit_checker.sv */
// ----------------------------------------------------------------------------
// Timer tone unit checker
// Mirrors the timers, envelope and tone phase from the observed requests and
// register writes, and compares every result field against the prediction.
// ----------------------------------------------------------------------------
module chip8_timer_tone_unit_checker
	import ttu_pkg::*;
#(
	parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int TDATA_W         = ((SAMPLE_BITS + 17 + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [7:0]                s_tdata,   // load_value
	input  logic [1:0]                s_tuser,   // func
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	// sample, delay_value, sound_value, tone_on, zero pad
	input  logic [TDATA_W-1:0]        m_tdata,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [31:0]               cfg_data,
	output int unsigned               mismatch_count,
	output int unsigned               results_owed
);

	localparam int SINE_SIZE = 1 << SINE_INDEX_BITS;
	localparam int QUARTER   = SINE_SIZE / 4;
	localparam int PRODUCT_SHIFT = 31 - SAMPLE_BITS;
	localparam int PAD_LSB   = SAMPLE_BITS + 17;

	localparam longint unsigned ONE_Q28     = 64'd1 << 28;
	localparam longint unsigned HALF_PI_Q28 = 64'd421657428;
	localparam longint unsigned SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};

	typedef struct {
		logic [SAMPLE_BITS-1:0] sample;
		logic [7:0]             delay_value;
		logic [7:0]             sound_value;
		logic                   tone_on;
	} tone_result_t;

	tone_result_t tone_results_due [$];
	int           sine_lut [SINE_SIZE];

	logic [31:0] step_reg;
	logic [15:0] gain_reg;
	logic [14:0] peak_reg;
	logic [14:0] snap_reg;

	logic [7:0]  delay_q;
	logic [7:0]  sound_q;
	logic [31:0] phase_q;
	int          level_q;
	int unsigned result_index;

	// 32767 * sin(pi/2 * m / QUARTER), Taylor series in Q28, rounded
	function automatic int quarter_wave(int m);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned acc;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		x   = (HALF_PI_Q28 * longint'(m)) / QUARTER;
		x2  = (x * x) >> 28;
		acc = ONE_Q28;
		for (int i = 0; i < 6; i++) begin
			t   = ((x2 * acc) >> 28) / SERIES_DIV[i];
			acc = (t >= ONE_Q28) ? 64'd0 : ONE_Q28 - t;
		end
		s = (x * acc) >> 28;
		v = (s * 64'd32767 + (ONE_Q28 >> 1)) >> 28;
		if (v > 64'd32767)
			v = 64'd32767;
		return int'(v);
	endfunction

	initial begin
		int q;
		int m;
		int mag;
		for (int k = 0; k < SINE_SIZE; k++) begin
			q   = k / QUARTER;
			m   = k % QUARTER;
			mag = q[0] ? quarter_wave(QUARTER - m) : quarter_wave(m);
			sine_lut[k] = q[1] ? -mag : mag;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("tone result %0d: %s is %0h, expected %0h", result_index, what, got, want);
		mismatch_count++;
	endtask

	// Advance the timer and tone state by one request and queue its result.
	task automatic apply_request(input logic [1:0] func, input logic [7:0] load);
		tone_result_t r;
		longint       target;
		longint       lvl;
		longint       prod;
		int           idx;
		r.sample = '0;
		case (func)
			FUNC_TICK: begin
				if (delay_q != 0)
					delay_q = delay_q - 8'd1;
				if (sound_q != 0)
					sound_q = sound_q - 8'd1;
			end
			FUNC_SAMP: begin
				target = (sound_q != 0) ? longint'(peak_reg) : 64'sd0;
				// the product is floored, so a rise can stall just below target
				lvl = longint'(level_q) +
					(((target - longint'(level_q)) * longint'(gain_reg)) >>> 16);
				if (sound_q == 0 && lvl < longint'(snap_reg))
					lvl = 0;
				if (lvl < 0)
					lvl = 0;
				if (lvl > 32767)
					lvl = 32767;
				level_q  = int'(lvl);
				idx      = int'(phase_q >> (32 - SINE_INDEX_BITS));
				prod     = (longint'(level_q) * longint'(sine_lut[idx])) >>> PRODUCT_SHIFT;
				r.sample = prod[SAMPLE_BITS-1:0];
				phase_q  = phase_q + step_reg;
			end
			FUNC_LDD: delay_q = load;
			default:  sound_q = load;
		endcase
		r.delay_value = delay_q;
		r.sound_value = sound_q;
		r.tone_on     = (sound_q != 0);
		tone_results_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		tone_result_t want;
		if (!arst_n) begin
			step_reg = PHASE_STEP_RST;
			gain_reg = RAMP_GAIN_RST;
			peak_reg = PEAK_VOLUME_RST;
			snap_reg = SNAP_LEVEL_RST;
			delay_q  = '0;
			sound_q  = '0;
			phase_q  = '0;
			level_q  = 0;
			tone_results_due.delete();
			result_index   = 0;
			mismatch_count = 0;
			results_owed   = 0;
		end else begin
			// results first: a request accepted this edge cannot have one yet
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (tone_results_due.size() == 0) begin
					report_mismatch("result with no request pending", m_tdata, '0);
				end else begin
					want = tone_results_due.pop_front();
					if (m_tdata[SAMPLE_BITS-1:0] !== want.sample)
						report_mismatch("sample", m_tdata[SAMPLE_BITS-1:0], want.sample);
					if (m_tdata[SAMPLE_BITS+7:SAMPLE_BITS] !== want.delay_value)
						report_mismatch("delay_value", m_tdata[SAMPLE_BITS+7:SAMPLE_BITS],
							want.delay_value);
					if (m_tdata[SAMPLE_BITS+15:SAMPLE_BITS+8] !== want.sound_value)
						report_mismatch("sound_value", m_tdata[SAMPLE_BITS+15:SAMPLE_BITS+8],
							want.sound_value);
					if (m_tdata[SAMPLE_BITS+16] !== want.tone_on)
						report_mismatch("tone_on", m_tdata[SAMPLE_BITS+16], want.tone_on);
					if (m_tdata[TDATA_W-1:PAD_LSB] !== '0)
						report_mismatch("pad bits", m_tdata[TDATA_W-1:PAD_LSB], '0);
				end
				result_index++;
			end
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				case (cfg_index)
					REG_PHASE_STEP:  step_reg = cfg_data;
					REG_RAMP_GAIN:   gain_reg = cfg_data[15:0];
					REG_PEAK_VOLUME: peak_reg = cfg_data[14:0];
					REG_SNAP_LEVEL:  snap_reg = cfg_data[14:0];
					default: ;
				endcase
			end
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				apply_request(s_tuser, s_tdata);
			results_owed = tone_results_due.size();
		end
	end

endmodule

/* tb/sv/chip8_timer_tone_unit_top_tb.sv */
// ----------------------------------------------------------------------------
// Timer tone unit testbench
// Drives timer ticks, timer loads and sample requests under several register
// settings with random gaps on both stream sides; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module chip8_timer_tone_unit_top_tb;
	import ttu_pkg::*;

	localparam int TDATA_W         = ((SAMPLE_BITS_DEF + 17 + 7) / 8) * 8;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 216;
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 400000;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [7:0]                s_tdata;   // load_value
	logic [1:0]                s_tuser;   // func
	logic                      m_tvalid;
	logic                      m_tready;
	// sample, delay_value, sound_value, tone_on, zero pad
	logic [TDATA_W-1:0]        m_tdata;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [31:0]               cfg_data;

	int unsigned mismatch_count;
	int unsigned results_owed;
	int unsigned cycle_count = 0;
	int unsigned func_count [4] = '{0, 0, 0, 0};
	int unsigned settings_count = 1;
	int unsigned sent = 0;
	logic        tx_burst = 1'b0;
	logic        rx_burst = 1'b0;

	chip8_timer_tone_unit_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	chip8_timer_tone_unit_checker #(.TDATA_W(TDATA_W)) tone_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results owed", cycle_count, results_owed);
			$display("chip8_timer_tone_unit_top_tb: done, errors");
			$finish;
		end
	end

	// Result side: stall a random number of cycles before each result.
	initial begin
		int unsigned stall;
		int unsigned taken;
		taken    = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			@(negedge clk);
			taken++;
			if (taken % 32 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// Hold the request after a random gap until it is taken.
	task automatic issue_request(input logic [1:0] func, input logic [7:0] load);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= load;
		do @(posedge clk); while (s_tready !== 1'b1);
		@(negedge clk);
		func_count[func]++;
		sent++;
		if (sent % 32 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
	endtask

	// Write every register, plus one unused index that must be ignored.
	task automatic program_settings(input logic [31:0] step, input logic [31:0] gain,
			input logic [31:0] peak, input logic [31:0] snap);
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_RAMP_GAIN, gain);
		write_reg(REG_PEAK_VOLUME, peak);
		write_reg(CFG_INDEX_BITS'($urandom_range(REG_SNAP_LEVEL + 1,
			(1 << CFG_INDEX_BITS) - 1)), $urandom());
		write_reg(REG_SNAP_LEVEL, snap);
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	// Drop valid and let every owed result come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (results_owed == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned pick;
		logic [1:0]  func;
		logic [7:0]  load;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = FUNC_TICK;
		cfg_valid = 1'b0;
		cfg_index = REG_PHASE_STEP;
		cfg_data  = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: ticks at zero, loads at both extremes, rise and fade
		issue_request(FUNC_TICK, 8'h00);
		issue_request(FUNC_SAMP, 8'hff);
		issue_request(FUNC_LDD, 8'hff);
		issue_request(FUNC_LDS, 8'hff);
		issue_request(FUNC_SAMP, 8'h00);
		issue_request(FUNC_SAMP, 8'h55);
		issue_request(FUNC_TICK, 8'haa);
		issue_request(FUNC_LDD, 8'h00);
		issue_request(FUNC_LDS, 8'h01);
		issue_request(FUNC_TICK, 8'h00);
		issue_request(FUNC_TICK, 8'h00);
		issue_request(FUNC_SAMP, 8'h00);
		// full gain: the floored step stalls one below the peak
		drain();
		program_settings(32'hffff_ffff, 32'h0000_ffff, 32'h0000_7fff, 32'd20000);
		issue_request(FUNC_LDS, 8'h03);
		issue_request(FUNC_SAMP, 8'h00);
		issue_request(FUNC_SAMP, 8'h00);
		// zero gain holds the level away from its target
		drain();
		program_settings(32'd1, 32'd0, 32'd0, 32'd0);
		issue_request(FUNC_SAMP, 8'h00);
		// lowered peak decays, then fade-out snaps below the threshold
		drain();
		program_settings(32'd0, 32'h0000_8000, 32'd1000, 32'd20000);
		issue_request(FUNC_SAMP, 8'h00);
		issue_request(FUNC_LDS, 8'h00);
		issue_request(FUNC_SAMP, 8'h00);
		issue_request(FUNC_SAMP, 8'h00);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			case (p)
				0: program_settings(PHASE_STEP_RST, RAMP_GAIN_RST, PEAK_VOLUME_RST,
					SNAP_LEVEL_RST);
				1: program_settings(32'hffff_ffff, 32'h0000_ffff, 32'h0000_7fff,
					32'h0000_7fff);
				2: program_settings(32'd0, 32'd0, 32'd0, 32'd0);
				3: program_settings(32'h8000_0000, 32'h0000_ffff, 32'h0000_7fff,
					SNAP_LEVEL_RST);
				4: program_settings($urandom(), 32'd0, $urandom(), 32'h0000_7fff);
				5: program_settings($urandom(), $urandom_range(1, 4000),
					$urandom_range(8000, 32767), $urandom_range(0, 200));
				default: program_settings($urandom(), $urandom(), $urandom(), $urandom());
			endcase
			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				load = 8'($urandom());
				if (pick < 45) begin
					func = FUNC_SAMP;
				end else if (pick < 70) begin
					func = FUNC_TICK;
				end else if (pick < 85) begin
					func = FUNC_LDS;
					// keep the sound timer short so the tone turns on and off
					pick = $urandom_range(0, 9);
					if (pick < 3)
						load = 8'd0;
					else if (pick < 7)
						load = 8'($urandom_range(1, 12));
				end else begin
					func = FUNC_LDD;
				end
				issue_request(func, load);
			end
		end
		drain();

		$display("covered %0d requests: %0d ticks, %0d samples, %0d delay and %0d sound loads",
			sent, func_count[FUNC_TICK], func_count[FUNC_SAMP], func_count[FUNC_LDD],
			func_count[FUNC_LDS]);
		$display("across %0d register settings, %0d mismatches", settings_count,
			mismatch_count);
		if (mismatch_count == 0)
			$display("chip8_timer_tone_unit_top_tb: done, clean");
		else
			$display("chip8_timer_tone_unit_top_tb: done, errors");
		$finish;
	end

endmodule

/* chip8_timer_tone_unit_top.f */
+incdir+hw/rtl
hw/rtl/ttu_pkg.sv
hw/rtl/chip8_timer_tone_unit_top.sv
tb/sv/chip8_timer_tone_unit_checker.sv
tb/sv/chip8_timer_tone_unit_top_tb.sv
